// File: hdl/lcae_pkg.sv
// Package for the life cellular automaton engine.
// Holds operation codes, field widths, rule constants and the default grid size.
// No dependencies.
`default_nettype none

package lcae_pkg;

  // Item field widths
  localparam int MODE_W  = 3;
  localparam int COORD_W = 6;

  // Default grid edge length (cells per row and rows per grid)
  localparam int GRID_SIZE_DEF = 64;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_SET_ALIVE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_DEAD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage : lcae_pkg

`default_nettype wire

// File: hdl/lcae_cmd_if.sv
// Command channel: valid/ready handshake carrying mode, row and col.
// Depends on lcae_pkg for field widths.
`default_nettype none

interface lcae_cmd_if import lcae_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (output valid, output mode, output row, output col, input ready);
  modport sink   (input valid, input mode, input row, input col, output ready);
endinterface : lcae_cmd_if

`default_nettype wire

// File: hdl/lcae_res_if.sv
// Result channel: valid/ready handshake carrying cell_value and done_res.
// Depends on lcae_pkg (imported for consistency with the command channel).
`default_nettype none

interface lcae_res_if import lcae_pkg::*; ();
  logic valid;
  logic ready;
  logic cell_value;
  logic done_res;

  modport source (output valid, output cell_value, output done_res, input ready);
  modport sink   (input valid, input cell_value, input done_res, output ready);
endinterface : lcae_res_if

`default_nettype wire

// File: hdl/lcae_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lcae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : lcae_ram

`default_nettype wire

// File: hdl/lcae_row_calc.sv
// Next-generation row under B3/S23 from three consecutive rows of the old grid.
// Border columns pass through unchanged. Depends on lcae_pkg.
`default_nettype none

module lcae_row_calc import lcae_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic [GRID_SIZE-1:0] above_i,
  input  wire logic [GRID_SIZE-1:0] mid_i,
  input  wire logic [GRID_SIZE-1:0] below_i,
  output logic      [GRID_SIZE-1:0] next_o
);

  for (genvar c = 0; c < GRID_SIZE; c++) begin : g_cell
    if (c == 0 || c == GRID_SIZE - 1) begin : g_border
      assign next_o[c] = mid_i[c];
    end else begin : g_inner
      logic [3:0] nbr_cnt;

      // Eight-neighbor population count
      assign nbr_cnt = 4'(above_i[c-1]) + 4'(above_i[c]) + 4'(above_i[c+1])
                     + 4'(mid_i[c-1])                     + 4'(mid_i[c+1])
                     + 4'(below_i[c-1]) + 4'(below_i[c]) + 4'(below_i[c+1]);

      assign next_o[c] = (nbr_cnt == BIRTH_COUNT)
                       || (mid_i[c] && (nbr_cnt == SURVIVE_COUNT));
    end
  end

endmodule : lcae_row_calc

`default_nettype wire

// File: hdl/life_cellular_automaton_engine_core.sv
// Game of Life (B3/S23) engine. The grid is kept one row per word in a RAM of
// GRID_SIZE words by GRID_SIZE bits, and every operation moves at most one row
// through the single read port and the single write port per cycle. After
// reset the block sweeps the RAM to all dead with the command channel not
// ready. Set alive, set dead and read go from acceptance to the result through
// the steps read row, modify/select, present; an address outside the grid and
// an unknown mode go straight to present. Clear rewrites every row. A
// generation streams the rows through two line registers and writes each
// interior row back as soon as the row below it has been read. One item is
// processed at a time; the next item is accepted while the previous result still
// waits in the output register.
// Depends on lcae_pkg, lcae_cmd_if, lcae_res_if, lcae_ram and lcae_row_calc.
`default_nettype none

module life_cellular_automaton_engine_core import lcae_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lcae_cmd_if.sink    cmd_i,
  lcae_res_if.source  res_o
);

  localparam int ROW_W = $clog2(GRID_SIZE);
  localparam int CMP_W = ((ROW_W > COORD_W) ? ROW_W : COORD_W) + 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ACCESS = 3'd2;
  localparam logic [2:0] S_GEN    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [ROW_W-1:0]     cnt_q, cnt_d;
  logic                 clr_cmd_q, clr_cmd_d;
  logic [MODE_W-1:0]    op_q, op_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [ROW_W-1:0]     col_q, col_d;
  logic [GRID_SIZE-1:0] above_q, above_d;
  logic [GRID_SIZE-1:0] mid_q, mid_d;
  logic                 fin_value_q, fin_value_d;
  logic                 fin_done_q, fin_done_d;
  logic                 res_valid_q, res_valid_d;
  logic                 res_value_q, res_value_d;
  logic                 res_done_q, res_done_d;

  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr;
  logic [GRID_SIZE-1:0] ram_wdata;
  logic                 ram_re;
  logic [ROW_W-1:0]     ram_raddr;
  logic [GRID_SIZE-1:0] ram_rdata;
  logic [GRID_SIZE-1:0] next_row;

  logic                 cmd_acc;
  logic                 in_grid;
  logic [CMP_W-1:0]     row_ext;
  logic [CMP_W-1:0]     col_ext;
  logic [GRID_SIZE-1:0] rmw_row;

  // Grid storage, one row per word
  lcae_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Rule evaluation for the row between above_q and the row just read
  lcae_row_calc #(
    .GRID_SIZE (GRID_SIZE)
  ) u_row_calc (
    .above_i (above_q),
    .mid_i   (mid_q),
    .below_i (ram_rdata),
    .next_o  (next_row)
  );

  // Handshake and address decode
  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign row_ext     = CMP_W'(cmd_i.row);
  assign col_ext     = CMP_W'(cmd_i.col);
  assign in_grid     = (row_ext < CMP_W'(GRID_SIZE)) && (col_ext < CMP_W'(GRID_SIZE));

  // Row with the addressed bit overwritten, for set alive / set dead
  always_comb begin
    rmw_row        = ram_rdata;
    rmw_row[col_q] = (op_q == MODE_SET_ALIVE);
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    clr_cmd_d   = clr_cmd_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    above_d     = above_q;
    mid_d       = mid_q;
    fin_value_d = fin_value_q;
    fin_done_d  = fin_done_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = ROW_W'(cmd_i.row);

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        if (cnt_q == LAST_ROW) begin
          clr_cmd_d   = 1'b0;
          fin_value_d = 1'b0;
          fin_done_d  = 1'b1;
          state_d     = clr_cmd_q ? S_FINISH : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (cmd_acc) begin
          op_d        = cmd_i.mode;
          row_d       = ROW_W'(cmd_i.row);
          col_d       = ROW_W'(cmd_i.col);
          fin_value_d = 1'b0;
          fin_done_d  = 1'b1;
          case (cmd_i.mode)
            MODE_SET_ALIVE, MODE_SET_DEAD, MODE_READ: begin
              if (in_grid) begin
                ram_re    = 1'b1;
                ram_raddr = ROW_W'(cmd_i.row);
                state_d   = S_ACCESS;
              end else begin
                state_d = S_FINISH;
              end
            end
            MODE_CLEAR: begin
              cnt_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = S_CLEAR;
            end
            MODE_STEP: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              cnt_d     = '0;
              state_d   = S_GEN;
            end
            default: begin
              fin_done_d = 1'b0;
              state_d    = S_FINISH;
            end
          endcase
        end
      end

      S_ACCESS: begin
        if (op_q == MODE_READ) begin
          fin_value_d = ram_rdata[col_q];
        end else begin
          ram_we    = 1'b1;
          ram_waddr = row_q;
          ram_wdata = rmw_row;
        end
        state_d = S_FINISH;
      end

      S_GEN: begin
        // ram_rdata holds old row cnt_q; once cnt_q >= 2, write back new row cnt_q - 1
        ram_re    = 1'b1;
        ram_raddr = cnt_q + 1'b1;
        above_d   = mid_q;
        mid_d     = ram_rdata;
        if (cnt_q >= ROW_W'(2)) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q - 1'b1;
          ram_wdata = next_row;
        end
        if (cnt_q == LAST_ROW) begin
          fin_value_d = 1'b0;
          fin_done_d  = 1'b1;
          state_d     = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_FINISH: begin
        if (!res_valid_q || res_o.ready) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    res_valid_d = res_valid_q;
    res_value_d = res_value_q;
    res_done_d  = res_done_q;
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end
    if ((state_q == S_FINISH) && (!res_valid_q || res_o.ready)) begin
      res_valid_d = 1'b1;
      res_value_d = fin_value_q;
      res_done_d  = fin_done_q;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.cell_value = res_value_q;
  assign res_o.done_res   = res_done_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_cmd_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_cmd_q   <= clr_cmd_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and line registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    row_q       <= row_d;
    col_q       <= col_d;
    above_q     <= above_d;
    mid_q       <= mid_d;
    fin_value_q <= fin_value_d;
    fin_done_q  <= fin_done_d;
    res_value_q <= res_value_d;
    res_done_q  <= res_done_d;
  end

  // A generation never rewrites a border row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GEN && ram_we) |-> (ram_waddr != '0 && ram_waddr != LAST_ROW))
    else $error("generation wrote a border row");

  // The grid is never written while waiting for a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("RAM write while idle");

  // An accepted item closes the command channel until it is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> !cmd_i.ready)
    else $error("command accepted while busy");

  // The clearing sweep ends after its last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && cnt_q == LAST_ROW) |=> (state_q != S_CLEAR))
    else $error("clearing sweep overran");

  // A result is only loaded from the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == S_FINISH))
    else $error("result produced outside finish state");

endmodule : life_cellular_automaton_engine_core

`default_nettype wire
